/* rtl/chr_pkg.sv */
// Shared types and constants for the consistent hash ring core.
// Used by chr_cell, chr_tree and consistent_hash_ring_core.
// No dependencies.
package chr_pkg;

   // Ring geometry
   localparam int RING_DEPTH  = 1024;
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int NODE_W      = 6;

   // Reduction tree: cells per first-level group
   localparam int GROUP_SIZE  = 32;
   localparam int GROUP_COUNT = (RING_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   // Request opcodes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Response status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [NODE_W-1:0] node_type;
   typedef logic [CNT_W-1:0]  count_type;

   // Data one cell hands to the next one up the row
   typedef struct packed {
      key_type  key;
      node_type node;
      logic     ge;    // stored key >= request key (occupied cells only)
      logic     occ;   // cell holds a live entry
   } chr_link_type;

   // Per-cell contribution to the reduction tree
   typedef struct packed {
      logic     hit;   // first cell whose key >= request key
      logic     eq;    // stored key equals request key
      node_type node;  // node of the hit cell, zero elsewhere
   } chr_tap_type;

   // Broadcast command from the sequencer to every cell
   typedef struct packed {
      logic     load;    // capture compare flags against key
      logic     shift;   // open a slot and insert key/node
      logic     update;  // overwrite node of the equal-key cell
      key_type  key;
      node_type node;
   } chr_cmd_type;

endpackage

/* rtl/chr_cell.sv */
// One ring cell: holds a key/node pair and its compare flags.
// Depends on chr_pkg; instantiated in a row by consistent_hash_ring_core.
module chr_cell
   import chr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         occ,
   input  chr_cmd_type  cmd,
   input  chr_link_type prev_link,
   output chr_link_type link,
   output chr_tap_type  tap
);

   key_type  key_ff;
   node_type node_ff;
   logic     ge_ff;
   logic     eq_ff;
   logic     first;
   logic     take_new;

   // Boundary of the sorted run: this cell is the insert/lookup position
   assign first    = ge_ff & ~prev_link.ge;
   assign take_new = ~prev_link.ge & (ge_ff | ~occ) & prev_link.occ;

   // Compare flags
   always_ff @(posedge clock) begin
      if (reset) begin
         ge_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else if (cmd.load) begin
         ge_ff <= occ & (key_ff >= cmd.key);
         eq_ff <= occ & (key_ff == cmd.key);
      end
   end

   // Entry storage: shift from the neighbor, take the new entry, or update
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         if (prev_link.ge) begin
            key_ff  <= prev_link.key;
            node_ff <= prev_link.node;
         end else if (take_new) begin
            key_ff  <= cmd.key;
            node_ff <= cmd.node;
         end
      end else if (cmd.update && eq_ff) begin
         node_ff <= cmd.node;
      end
   end

   assign link.key  = key_ff;
   assign link.node = node_ff;
   assign link.ge   = ge_ff;
   assign link.occ  = occ;

   assign tap.hit  = first;
   assign tap.eq   = eq_ff;
   assign tap.node = first ? node_ff : '0;

endmodule

/* rtl/chr_tree.sv */
// Two-level registered OR tree that gathers cell taps into one summary.
// Depends on chr_pkg; used by consistent_hash_ring_core.
module chr_tree
   import chr_pkg::*;
(
   input  logic        clock,
   input  chr_tap_type taps [RING_DEPTH],
   output chr_tap_type summary
);

   chr_tap_type group_in [GROUP_COUNT];
   chr_tap_type group_ff [GROUP_COUNT];
   chr_tap_type sum_in;
   chr_tap_type sum_ff;

   // First level: OR within each group of cells
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < RING_DEPTH) begin
               group_in[g] = group_in[g] | taps[g * GROUP_SIZE + j];
            end
         end
      end
   end

   // Second level: OR across groups
   always_comb begin
      sum_in = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         sum_in = sum_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      sum_ff   <= sum_in;
   end

   assign summary = sum_ff;

endmodule

/* rtl/consistent_hash_ring_core.sv */
// Top level of the consistent hash ring core: sequencer, cell row, tree.
// Depends on chr_pkg, chr_cell and chr_tree.
//
// Usage:
//   Requests enter on req_* (valid/ready) with an opcode, a 32-bit key and
//   a node index. Clear empties the ring, insert places a key in sorted
//   order (or replaces the node of an equal key), lookup returns the node
//   of the smallest key not below the query, wrapping to the smallest key.
//   Every request gives one response on rsp_* (valid/ready): a status and
//   the selected node.
//   After a request is accepted, every cell compares at the accepting
//   edge, then come the two levels of the registered OR tree and a commit
//   cycle in which the row shifts and the response register loads. A new
//   request is not taken until the last one has committed, as set by that
//   compare/reduce/commit sequence.
//   Reset empties the ring (entry count zero) and drops any response.
//   A new request is accepted while a response waits; if the receiver
//   stalls, the next request holds in its commit cycle, with req_ready
//   low, until the waiting response is taken.
module consistent_hash_ring_core
   import chr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [NODE_W-1:0] req_node_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [NODE_W-1:0] rsp_selected_node
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_GROUP,
      S_SUM,
      S_FINISH
   } state_type;

   state_type    state_ff;
   count_type    count_ff;
   logic [1:0]   op_ff;
   key_type      key_ff;
   node_type     node_ff;
   logic         rsp_valid_ff;
   logic [1:0]   rsp_status_ff;
   node_type     rsp_node_ff;
   logic [1:0]   rsp_status_in;
   node_type     rsp_node_in;

   logic         accept;
   logic         commit;
   logic         full;
   chr_cmd_type  cmd;
   chr_tap_type  summary;
   logic         occ   [RING_DEPTH];
   chr_link_type links [RING_DEPTH];
   chr_tap_type  taps  [RING_DEPTH];
   chr_link_type seed_link;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign commit    = (state_ff == S_FINISH) & (~rsp_valid_ff | rsp_ready);
   assign full      = (count_ff == CNT_W'(RING_DEPTH));

   // Broadcast command to the cell row
   always_comb begin
      cmd        = '0;
      cmd.load   = accept;
      cmd.key    = accept ? req_key : key_ff;
      cmd.node   = node_ff;
      if (commit && op_ff == OP_INSERT) begin
         cmd.update = summary.eq;
         cmd.shift  = ~summary.eq & ~full;
      end
   end

   // Below cell zero sits a virtual occupied entry smaller than any key
   always_comb begin
      seed_link     = '0;
      seed_link.occ = 1'b1;
   end

   // Cell row
   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count_ff);
      chr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .occ       (occ[i]),
         .cmd       (cmd),
         .prev_link ((i == 0) ? seed_link : links[(i == 0) ? 0 : i - 1]),
         .link      (links[i]),
         .tap       (taps[i])
      );
   end

   chr_tree u_tree (
      .clock   (clock),
      .taps    (taps),
      .summary (summary)
   );

   // Response contents for the request in its commit cycle
   always_comb begin
      rsp_status_in = STAT_OK;
      rsp_node_in   = '0;
      case (op_ff)
         OP_INSERT: begin
            if (!summary.eq && full) begin
               rsp_status_in = STAT_FULL;
            end
         end
         OP_LOOKUP: begin
            if (count_ff == '0) begin
               rsp_status_in = STAT_EMPTY;
            end else if (summary.hit) begin
               rsp_node_in = summary.node;
            end else begin
               // query above every key: wrap to the smallest
               rsp_node_in = links[0].node;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer, entry count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_opcode;
                  key_ff   <= req_key;
                  node_ff  <= req_node_index;
                  state_ff <= S_GROUP;
               end
            end
            S_GROUP: begin
               state_ff <= S_SUM;
            end
            S_SUM: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (commit) begin
                  rsp_status_ff <= rsp_status_in;
                  rsp_node_ff   <= rsp_node_in;
                  case (op_ff)
                     OP_CLEAR: begin
                        count_ff <= '0;
                     end
                     OP_INSERT: begin
                        if (!summary.eq && !full) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     default: begin
                     end
                  endcase
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_selected_node = rsp_node_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("entry count above ring depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("response raised outside commit cycle");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_FULL) |-> full)
      else $error("full status while ring not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_EMPTY) |-> count_ff == '0)
      else $error("empty status while ring holds entries");

endmodule

/* sim/tb_consistent_hash_ring_core.sv */
// Testbench for consistent_hash_ring_core: directed and random insert, lookup, clear and
// unused-opcode requests, checked against a sorted-ring predictor held in a small scoreboard.
// Depends on chr_pkg and the consistent_hash_ring_core RTL.
`timescale 1ns / 100ps

module tb_consistent_hash_ring_core
   import chr_pkg::*;
();

   // Opcode the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LONG_HOLD = 200;

   typedef struct packed {
      logic [1:0] status;
      node_type   node;
   } ring_answer_type;

   // Predicts each response from its own copy of the ring and checks the DUT output
   class ring_scoreboard;
      key_type         ring_key  [RING_DEPTH];
      node_type        ring_node [RING_DEPTH];
      int unsigned     live_count;
      ring_answer_type answers [$];
      int unsigned     error_count;

      function new();
         live_count  = 0;
         error_count = 0;
      endfunction

      // First slot whose key is not below q; live_count when none
      function int unsigned ceil_slot(key_type q);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = live_count;
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (ring_key[mid] < q) lo = mid + 1;
            else hi = mid;
         end
         return lo;
      endfunction

      // A key already on the ring, or a random one when the ring is empty
      function key_type any_key();
         if (live_count == 0) return $urandom();
         return ring_key[$urandom_range(0, live_count - 1)];
      endfunction

      function int unsigned pending();
         return answers.size();
      endfunction

      // Accepted request: update the ring and queue the expected response
      function void note_request(logic [1:0] op, key_type key, node_type node);
         int unsigned     pos;
         ring_answer_type ans;
         ans.status = STAT_OK;
         ans.node   = '0;
         case (op)
            OP_CLEAR: begin
               live_count = 0;
            end
            OP_INSERT: begin
               // 6-bit index is stored as is
               pos = ceil_slot(key);
               if (pos < live_count && ring_key[pos] == key) begin
                  ring_node[pos] = node;
               end else if (live_count >= RING_DEPTH) begin
                  ans.status = STAT_FULL;
               end else begin
                  for (int i = live_count; i > pos; i--) begin
                     ring_key[i]  = ring_key[i-1];
                     ring_node[i] = ring_node[i-1];
                  end
                  ring_key[pos]  = key;
                  ring_node[pos] = node;
                  live_count++;
               end
            end
            OP_LOOKUP: begin
               if (live_count == 0) begin
                  ans.status = STAT_EMPTY;
               end else begin
                  pos = ceil_slot(key);
                  if (pos >= live_count) pos = 0;   // wrap to smallest key
                  ans.node = ring_node[pos];
               end
            end
            default: ;
         endcase
         answers.push_back(ans);
      endfunction

      function void check_response(logic [1:0] status, node_type node);
         ring_answer_type ans;
         if (answers.size() == 0) begin
            $error("response with no request outstanding: status %0d node %0d",
                   status, node);
            error_count++;
            return;
         end
         ans = answers.pop_front();
         if (status !== ans.status) begin
            $error("status mismatch: expected %0d, actual %0d", ans.status, status);
            error_count++;
         end
         if (node !== ans.node) begin
            $error("selected_node mismatch: expected %0d, actual %0d", ans.node, node);
            error_count++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = OP_CLEAR;
   key_type    req_key = '0;
   node_type   req_node_index = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   node_type   rsp_selected_node;

   ring_scoreboard sb = new();
   int unsigned    req_count = 0;
   int unsigned    rsp_count = 0;

   consistent_hash_ring_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_key           (req_key),
      .req_node_index    (req_node_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_selected_node (rsp_selected_node)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle cycles before a request; some stretches run back to back
   function automatic int unsigned draw_gap(int unsigned n);
      if ((n % 256) < 48) return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic key_type draw_key();
      key_type k;
      case ($urandom_range(0, 9))
         0:       k = '0;
         1:       k = '1;
         2, 3, 4: k = sb.any_key();
         5:       k = sb.any_key() + 1;
         6:       k = sb.any_key() - 1;
         default: k = $urandom();
      endcase
      return k;
   endfunction

   function automatic node_type draw_node();
      return node_type'($urandom_range(0, (1 << NODE_W) - 1));
   endfunction

   // Offer one request and hold it until accepted
   task automatic send_request(logic [1:0] op, key_type key, node_type node);
      int unsigned gap;
      gap = draw_gap(req_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_key        <= key;
      req_node_index <= node;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, key, node);
      req_count++;
   endtask

   // Response side: random stalls, two long holds to back the block up
   initial begin
      int unsigned gap;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_count == 150 || rsp_count == 1300) gap = LONG_HOLD;
         else gap = draw_gap(rsp_count);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_status, rsp_selected_node);
         rsp_count++;
      end
   end

   // Stimulus
   initial begin
      int unsigned pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty ring, ignored opcode, extremes, replace, wrap
      send_request(OP_LOOKUP, 32'h0000_0000, 6'd0);
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
      send_request(OP_INSERT, 32'h8000_0000, 6'd5);
      send_request(OP_INSERT, 32'h0000_0000, 6'd0);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 6'd63);
      send_request(OP_INSERT, 32'h8000_0000, 6'd42);
      send_request(OP_LOOKUP, 32'h0000_0000, 6'd63);
      send_request(OP_LOOKUP, 32'h0000_0001, 6'd0);
      send_request(OP_LOOKUP, 32'h8000_0000, 6'd0);
      send_request(OP_LOOKUP, 32'h8000_0001, 6'd0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
      send_request(OP_CLEAR,  32'hFFFF_FFFF, 6'd63);
      send_request(OP_INSERT, 32'h0000_1000, 6'd7);
      send_request(OP_LOOKUP, 32'h0000_2000, 6'd0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
      send_request(OP_INSERT, 32'h0000_0FFF, 6'd3);
      send_request(OP_INSERT, 32'h5555_5555, 6'd21);
      send_request(OP_INSERT, 32'hAAAA_AAAA, 6'd42);
      send_request(OP_LOOKUP, 32'h5555_5555, 6'd0);
      send_request(OP_LOOKUP, 32'hAAAA_AAAB, 6'd0);
      send_request(OP_UNUSED, 32'h5555_5555, 6'd21);
      send_request(OP_CLEAR,  32'h0000_0000, 6'd0);
      send_request(OP_LOOKUP, 32'h1234_5678, 6'd0);

      // Mixed traffic on a partly filled ring, cleared now and then
      repeat (550) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) send_request(OP_CLEAR, $urandom(), draw_node());
         else if (pick < 4) send_request(OP_UNUSED, $urandom(), draw_node());
         else if (pick < 50) send_request(OP_INSERT, draw_key(), draw_node());
         else send_request(OP_LOOKUP, draw_key(), draw_node());
      end

      // Fill the table completely, with lookups interleaved
      send_request(OP_CLEAR, '0, '0);
      while (sb.live_count < RING_DEPTH) begin
         if ($urandom_range(0, 7) == 0) send_request(OP_LOOKUP, draw_key(), draw_node());
         else send_request(OP_INSERT, $urandom(), draw_node());
      end

      // Full table: new keys refused, equal keys still replaced
      repeat (60) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) send_request(OP_INSERT, $urandom(), draw_node());
         else if (pick < 55) send_request(OP_INSERT, sb.any_key(), draw_node());
         else send_request(OP_LOOKUP, draw_key(), draw_node());
      end
      send_request(OP_INSERT, 32'hFFFF_FFFF, 6'd63);
      send_request(OP_CLEAR, '0, '0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
      req_valid <= 1'b0;

      // Drain, then wait for anything stray
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("consistent_hash_ring_core test passed");
      end else begin
         $display("consistent_hash_ring_core test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("consistent_hash_ring_core test failed");
      $finish;
   end

endmodule
